/* hdl/harmonic_bond_force_defines.svh */
// Assertion macros used by the checker file.
`ifndef HARMONIC_BOND_FORCE_DEFINES_SVH
`define HARMONIC_BOND_FORCE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define HBF_ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define HBF_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

/* hdl/hbf_pkg.sv */
// Package: widths, stage counts, types and step functions of the bond force pipeline.
package hbf_pkg;

  localparam int COORD_W    = 32;
  localparam int FRAC_W     = 16;
  localparam int CFG_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int OUT_W      = 48;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int SUM_W      = 2 * DIFF_W;
  localparam int ROOT_W     = SUM_W / 2;
  localparam int REM_W      = ROOT_W + 3;
  localparam int DR_W       = ROOT_W + 1;
  localparam int KD_W       = CFG_W + ROOT_W;
  localparam int DRSQ_W     = 2 * ROOT_W;
  localparam int EP_W       = DRSQ_W + CFG_W;
  localparam int Q_W        = KD_W + 1;
  localparam int T_W        = Q_W + ROOT_W;
  localparam int SQ_PER     = 3;
  localparam int SQ_STAGES  = ROOT_W / SQ_PER;
  localparam int DIV_PER    = 3;
  localparam int DIV_STAGES = Q_W / DIV_PER;
  // diff, square, sum, root stages, stretch, mul, partials, combine, divide, output
  localparam int NSTAGE     = 8 + SQ_STAGES + DIV_STAGES;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPRING = 2'd0,
    REG_REST   = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [SUM_W-1:0]  rad;
  } sq_state_t;

  typedef struct packed {
    logic [ROOT_W-1:0] rem;
    logic [Q_W-1:0]    num;
  } dv_state_t;

  typedef struct packed {
    logic [2:0][DIFF_W-1:0] dabs;
    logic [2:0]             dneg;
  } sq_tag_t;

  typedef struct packed {
    logic [OUT_W-1:0] energy;
    logic [2:0]       dneg;
    logic             drneg;
    logic             rzero;
  } dv_tag_t;

  typedef struct packed {
    logic [OUT_W-1:0]      energy;
    logic [2:0][OUT_W-1:0] f1;
    logic [2:0][OUT_W-1:0] f2;
  } out_t;

  // one digit of the square root: two radicand bits in, one root bit out
  function automatic sq_state_t sqrt_step(sq_state_t s);
    sq_state_t        r;
    logic [REM_W-1:0] acc;
    logic [REM_W-1:0] trial;
    acc   = {s.rem[REM_W-3:0], s.rad[SUM_W-1 -: 2]};
    trial = {{(REM_W-ROOT_W-2){1'b0}}, s.root, 2'b01};
    r.rad = {s.rad[SUM_W-3:0], 2'b00};
    if (acc >= trial) begin
      r.rem  = acc - trial;
      r.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      r.rem  = acc;
      r.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    return r;
  endfunction

  // one restoring division step: quotient bit shifts into num
  function automatic dv_state_t div_step(dv_state_t s, logic [ROOT_W-1:0] dv);
    dv_state_t       r;
    logic [ROOT_W:0] acc;
    acc   = {s.rem, s.num[Q_W-1]};
    r.num = {s.num[Q_W-2:0], 1'b0};
    if (acc >= {1'b0, dv}) begin
      acc      = acc - {1'b0, dv};
      r.num[0] = 1'b1;
    end
    r.rem = acc[ROOT_W-1:0];
    return r;
  endfunction

endpackage

/* hdl/hbf_isqrt.sv */
// Pipelined integer square root, several root bits per stage, with a side tag.
module hbf_isqrt import hbf_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [SUM_W-1:0]  rad,
  input  sq_tag_t           tag_in,
  output logic [ROOT_W-1:0] root,
  output sq_tag_t           tag_out
);

  sq_state_t st [SQ_STAGES];
  sq_tag_t   tg [SQ_STAGES];

  for (genvar s = 0; s < SQ_STAGES; s++) begin : g_st
    sq_state_t src;
    sq_tag_t   tsrc;
    sq_state_t cur [SQ_PER+1];

    if (s == 0) begin : g_in
      assign src  = '{rem: '0, root: '0, rad: rad};
      assign tsrc = tag_in;
    end else begin : g_mid
      assign src  = st[s-1];
      assign tsrc = tg[s-1];
    end

    always_comb begin
      cur[0] = src;
      for (int j = 0; j < SQ_PER; j++) begin
        cur[j+1] = sqrt_step(cur[j]);
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[s] <= cur[SQ_PER];
        tg[s] <= tsrc;
      end
    end
  end

  assign root    = st[SQ_STAGES-1].root;
  assign tag_out = tg[SQ_STAGES-1];

endmodule

/* hdl/hbf_div.sv */
// Pipelined restoring divider, three lanes sharing one divisor, with a side tag.
module hbf_div import hbf_pkg::*; (
  input  logic                  clk,
  input  logic                  en,
  input  logic [ROOT_W-1:0]     dv_in,
  input  logic [2:0][T_W-1:0]   num_in,
  input  dv_tag_t               tag_in,
  output logic [2:0][Q_W-1:0]   quo,
  output dv_tag_t               tag_out
);

  dv_state_t [2:0]   st  [DIV_STAGES];
  logic [ROOT_W-1:0] dvr [DIV_STAGES];
  dv_tag_t           tg  [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_st
    dv_state_t [2:0]   src;
    logic [ROOT_W-1:0] dsrc;
    dv_tag_t           tsrc;
    dv_state_t [2:0]   cur [DIV_PER+1];

    if (s == 0) begin : g_in
      for (genvar i = 0; i < 3; i++) begin : g_lane
        assign src[i] = '{rem: num_in[i][T_W-1:Q_W], num: num_in[i][Q_W-1:0]};
      end
      assign dsrc = dv_in;
      assign tsrc = tag_in;
    end else begin : g_mid
      assign src  = st[s-1];
      assign dsrc = dvr[s-1];
      assign tsrc = tg[s-1];
    end

    always_comb begin
      cur[0] = src;
      for (int j = 0; j < DIV_PER; j++) begin
        for (int i = 0; i < 3; i++) begin
          cur[j+1][i] = div_step(cur[j][i], dsrc);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[s]  <= cur[DIV_PER];
        dvr[s] <= dsrc;
        tg[s]  <= tsrc;
      end
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_q
    assign quo[i] = st[DIV_STAGES-1][i].num;
  end
  assign tag_out = tg[DIV_STAGES-1];

endmodule

/* hdl/harmonic_bond_force.sv */
// Top level: harmonic bond energy and pair forces, fully pipelined.
// One atom pair enters per clock while in_stall is low; results leave in order.
// Most stages belong to the square root (11 stages, three root bits each) and the
// three-lane force divider (22 stages, three quotient bits each). A stalled output
// item is parked in a skid register, so in_stall is registered and rises in the
// cycle after out_stall blocks a valid item. Configuration writes are always taken.
module harmonic_bond_force import hbf_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]          cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [COORD_W-1:0] atom1_x,
  input  logic signed [COORD_W-1:0] atom1_y,
  input  logic signed [COORD_W-1:0] atom1_z,
  input  logic signed [COORD_W-1:0] atom2_x,
  input  logic signed [COORD_W-1:0] atom2_y,
  input  logic signed [COORD_W-1:0] atom2_z,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [OUT_W-1:0]          energy,
  output logic signed [OUT_W-1:0]  force1_x,
  output logic signed [OUT_W-1:0]  force1_y,
  output logic signed [OUT_W-1:0]  force1_z,
  output logic signed [OUT_W-1:0]  force2_x,
  output logic signed [OUT_W-1:0]  force2_y,
  output logic signed [OUT_W-1:0]  force2_z
);

  logic [CFG_W-1:0] spring;
  logic [CFG_W-1:0] rest;

  logic [NSTAGE-1:0] v;
  logic              adv;
  logic              skid_v;
  out_t              skid;
  out_t              res;
  out_t              shown;

  logic [2:0][COORD_W-1:0] a1;
  logic [2:0][COORD_W-1:0] a2;

  // stage regs
  logic [2:0][DIFF_W-1:0] dif_dabs;
  logic [2:0]             dif_dneg;
  logic [2:0][SUM_W-1:0]  sq_sq;
  sq_tag_t                sq_tag;
  logic [SUM_W-1:0]       sum_rad;
  sq_tag_t                sum_tag;
  logic [ROOT_W-1:0]      rt_root;
  sq_tag_t                rt_tag;
  logic [ROOT_W-1:0]      dr_r;
  logic [ROOT_W-1:0]      dr_abs;
  logic                   dr_neg;
  sq_tag_t                dr_tag;
  logic [ROOT_W-1:0]      mul_r;
  logic                   mul_neg;
  sq_tag_t                mul_tag;
  logic [KD_W-1:0]        mul_kd;
  logic [DRSQ_W-1:0]      mul_drsq;
  logic [ROOT_W-1:0]      pt_r;
  logic                   pt_neg;
  logic [2:0]             pt_dneg;
  logic [KD_W-1:0]        pt_elo;
  logic [KD_W-1:0]        pt_ehi;
  logic [2:0][KD_W-1:0]   pt_flo;
  logic [2:0][Q_W-1:0]    pt_fhi;
  logic [ROOT_W-1:0]      cb_r;
  logic [2:0][T_W-1:0]    cb_t;
  dv_tag_t                cb_tag;
  logic [2:0][Q_W-1:0]    quo;
  dv_tag_t                dv_tag;

  logic [DR_W-1:0]        dr_diff;
  logic [EP_W-1:0]        ep;
  logic [OUT_W-1:0]       e_sat;

  assign cfg_ready = 1'b1;
  assign adv       = !skid_v;
  assign in_stall  = skid_v;
  assign a1        = {atom1_z, atom1_y, atom1_x};
  assign a2        = {atom2_z, atom2_y, atom2_x};

  always_ff @(posedge clk) begin
    if (rst) begin
      spring <= '0;
      rest   <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SPRING: spring <= cfg_data;
        REG_REST:   rest   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v      <= '0;
      skid_v <= 1'b0;
    end else begin
      if (adv) begin
        v <= {v[NSTAGE-2:0], in_valid};
      end
      if (adv && v[NSTAGE-1] && out_stall) begin
        skid_v <= 1'b1;
      end else if (skid_v && !out_stall) begin
        skid_v <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && v[NSTAGE-1] && out_stall) begin
      skid <= res;
    end
  end

  // separation, magnitudes, squares, sum
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        logic [DIFF_W-1:0] d;
        d = {a2[i][COORD_W-1], a2[i]} - {a1[i][COORD_W-1], a1[i]};
        dif_dneg[i] <= d[DIFF_W-1];
        dif_dabs[i] <= d[DIFF_W-1] ? -d : d;
        sq_sq[i]    <= dif_dabs[i] * dif_dabs[i];
      end
      sq_tag  <= '{dabs: dif_dabs, dneg: dif_dneg};
      sum_rad <= sq_sq[0] + sq_sq[1] + sq_sq[2];
      sum_tag <= sq_tag;
    end
  end

  hbf_isqrt u_isqrt (
    .clk     (clk),
    .en      (adv),
    .rad     (sum_rad),
    .tag_in  (sum_tag),
    .root    (rt_root),
    .tag_out (rt_tag)
  );

  assign dr_diff = {1'b0, rt_root} - {{(DR_W-CFG_W){1'b0}}, rest};

  // stretch, products, partial products
  always_ff @(posedge clk) begin
    if (adv) begin
      dr_r     <= rt_root;
      dr_neg   <= dr_diff[DR_W-1];
      dr_abs   <= dr_diff[DR_W-1] ? ROOT_W'(-dr_diff) : dr_diff[ROOT_W-1:0];
      dr_tag   <= rt_tag;

      mul_r    <= dr_r;
      mul_neg  <= dr_neg;
      mul_tag  <= dr_tag;
      mul_kd   <= spring * dr_abs;
      mul_drsq <= dr_abs * dr_abs;

      pt_r     <= mul_r;
      pt_neg   <= mul_neg;
      pt_dneg  <= mul_tag.dneg;
      pt_elo   <= mul_drsq[ROOT_W-1:0] * spring;
      pt_ehi   <= mul_drsq[DRSQ_W-1:ROOT_W] * spring;
      for (int i = 0; i < 3; i++) begin
        pt_flo[i] <= mul_kd[CFG_W-1:0] * mul_tag.dabs[i];
        pt_fhi[i] <= mul_kd[KD_W-1:CFG_W] * mul_tag.dabs[i];
      end
    end
  end

  assign ep    = {{(EP_W-KD_W){1'b0}}, pt_elo} + {pt_ehi, {ROOT_W{1'b0}}};
  assign e_sat = (|ep[EP_W-1:2*FRAC_W+OUT_W]) ? '1 : ep[2*FRAC_W +: OUT_W];

  always_ff @(posedge clk) begin
    if (adv) begin
      cb_r          <= pt_r;
      cb_tag.energy <= e_sat;
      cb_tag.dneg   <= pt_dneg;
      cb_tag.drneg  <= pt_neg;
      cb_tag.rzero  <= (pt_r == '0);
      for (int i = 0; i < 3; i++) begin
        logic [T_W-2:0] p;
        p = {pt_fhi[i], {CFG_W{1'b0}}} + {{(T_W-1-KD_W){1'b0}}, pt_flo[i]};
        cb_t[i] <= {p, 1'b0};
      end
    end
  end

  hbf_div u_div (
    .clk     (clk),
    .en      (adv),
    .dv_in   (cb_r),
    .num_in  (cb_t),
    .tag_in  (cb_tag),
    .quo     (quo),
    .tag_out (dv_tag)
  );

  // saturate, sign, output register
  always_ff @(posedge clk) begin
    if (adv) begin
      res.energy <= dv_tag.energy;
      for (int i = 0; i < 3; i++) begin
        logic [OUT_W-1:0] mag;
        logic [OUT_W-1:0] f2;
        if (dv_tag.rzero) begin
          mag = '0;
        end else if (|quo[i][Q_W-1:FRAC_W+OUT_W-1]) begin
          mag = {1'b0, {(OUT_W-1){1'b1}}};
        end else begin
          mag = {1'b0, quo[i][FRAC_W +: OUT_W-1]};
        end
        f2 = (dv_tag.drneg == dv_tag.dneg[i]) ? -mag : mag;
        res.f2[i] <= f2;
        res.f1[i] <= -f2;
      end
    end
  end

  assign shown     = skid_v ? skid : res;
  assign out_valid = skid_v || v[NSTAGE-1];
  assign energy    = shown.energy;
  assign force1_x  = shown.f1[0];
  assign force1_y  = shown.f1[1];
  assign force1_z  = shown.f1[2];
  assign force2_x  = shown.f2[0];
  assign force2_y  = shown.f2[1];
  assign force2_z  = shown.f2[2];

endmodule

/* hdl/hbf_checker.sv */
// Port-level checker for the bond force block, bound to the top level.
`include "harmonic_bond_force_defines.svh"

module hbf_checker import hbf_pkg::*; (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic signed [OUT_W-1:0]  force1_x,
  input logic signed [OUT_W-1:0]  force1_y,
  input logic signed [OUT_W-1:0]  force1_z,
  input logic signed [OUT_W-1:0]  force2_x,
  input logic signed [OUT_W-1:0]  force2_y,
  input logic signed [OUT_W-1:0]  force2_z
);

  `HBF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "stalled item dropped")
  `HBF_ASSERT_IMPL(a_force_pair, out_valid, (force1_x + force2_x == 48'd0) && (force1_y + force2_y == 48'd0) && (force1_z + force2_z == 48'd0), "force1 is not -force2")
  `HBF_ASSERT_IMPL(a_force_sat, out_valid, (force2_x != 48'h8000_0000_0000) && (force2_y != 48'h8000_0000_0000) && (force2_z != 48'h8000_0000_0000), "force beyond saturation")
  `HBF_ASSERT_NEXT(a_skid_drain, in_stall && !out_stall, !in_stall, "input stall stuck")

endmodule

bind harmonic_bond_force hbf_checker u_hbf_checker (.*);

/* tb/tb_top.sv */
// Testbench for harmonic_bond_force: predicts energy and pair forces and checks every result.
`timescale 1ns / 100ps
module tb_top;
  import hbf_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [COORD_W-1:0] atom1_x = '0, atom1_y = '0, atom1_z = '0;
  logic signed [COORD_W-1:0] atom2_x = '0, atom2_y = '0, atom2_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [OUT_W-1:0] energy;
  logic signed [OUT_W-1:0] force1_x, force1_y, force1_z, force2_x, force2_y, force2_z;

  typedef struct {
    logic [OUT_W-1:0] en;
    logic [OUT_W-1:0] f1 [3];
    logic [OUT_W-1:0] f2 [3];
  } bond_result_t;

  bond_result_t pending_results[$];
  logic [31:0] k_reg, r0_reg;
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles = 0;
  string f1_name [3] = '{"force1_x", "force1_y", "force1_z"};
  string f2_name [3] = '{"force2_x", "force2_y", "force2_z"};

  harmonic_bond_force u_top (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic bond_result_t bond_predict(logic signed [31:0] a1 [3],
                                                logic signed [31:0] a2 [3]);
    bond_result_t res;
    logic signed [33:0] d;
    logic [32:0] dabs [3];
    logic [2:0] dneg;
    logic [65:0] sum;
    logic [33:0] root;
    logic [67:0] sq;
    logic signed [35:0] dr;
    logic [34:0] drabs;
    logic [191:0] prod;
    logic [OUT_W-1:0] mag;
    logic [OUT_W-1:0] f2;
    sum = '0;
    for (int i = 0; i < 3; i++) begin
      d = $signed(a2[i]) - $signed(a1[i]);
      dneg[i] = d < 0;
      dabs[i] = dneg[i] ? 33'(-d) : 33'(d);
      sum += 66'(dabs[i]) * 66'(dabs[i]);
    end
    root = '0;
    for (int b = 33; b >= 0; b--) begin
      sq = 68'(root | (34'd1 << b));
      sq = sq * sq;
      if (sq <= 68'(sum)) root = root | (34'd1 << b);
    end
    dr = $signed({2'b0, root}) - $signed({4'b0, r0_reg});
    drabs = dr < 0 ? 35'(-dr) : 35'(dr);
    prod = (192'(drabs) * 192'(drabs) * 192'(k_reg)) >> 32;
    res.en = (prod > 192'({OUT_W{1'b1}})) ? {OUT_W{1'b1}} : prod[OUT_W-1:0];
    for (int i = 0; i < 3; i++) begin
      mag = '0;
      if (root != 0) begin
        prod = 192'(k_reg) * 192'(drabs) * 192'(dabs[i]) * 2;
        prod = (prod / 192'(root)) >> 16;
        mag = (prod > 192'({1'b0, {(OUT_W-1){1'b1}}})) ?
              {1'b0, {(OUT_W-1){1'b1}}} : prod[OUT_W-1:0];
      end
      f2 = ((dr < 0) == dneg[i]) ? -mag : mag;
      res.f2[i] = f2;
      res.f1[i] = -f2;
    end
    return res;
  endfunction

  task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_SPRING) k_reg = val;
    else r0_reg = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (NSTAGE + 10) @(posedge clk);
  endtask

  task automatic send_pair(logic signed [31:0] a1 [3], logic signed [31:0] a2 [3]);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    {atom1_x, atom1_y, atom1_z} = {a1[0], a1[1], a1[2]};
    {atom2_x, atom2_y, atom2_z} = {a2[0], a2[1], a2[2]};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(bond_predict(a1, a2));
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(4))
      0: return $urandom();
      1: return 32'($signed($urandom_range(2000000)) - 1000000);
      2: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($signed($urandom_range(400000)) - 200000);
    endcase
  endfunction

  task automatic send_random(int n);
    logic signed [31:0] a1 [3], a2 [3];
    for (int j = 0; j < n; j++) begin
      for (int i = 0; i < 3; i++) begin
        a1[i] = rand_coord();
        a2[i] = ($urandom_range(3) == 0) ? rand_coord() :
                a1[i] + 32'($signed($urandom_range(600000)) - 300000);
      end
      if ($urandom_range(30) == 0) a2 = a1;
      send_pair(a1, a2);
    end
  endtask

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    bond_result_t exp_r;
    logic [OUT_W-1:0] got1 [3], got2 [3];
    if (!rst && out_valid && !out_stall) begin
      got1 = '{force1_x, force1_y, force1_z};
      got2 = '{force2_x, force2_y, force2_z};
      if (pending_results.size() == 0) begin
        $error("unexpected result");
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (energy !== exp_r.en) begin
          $error("energy exp %h got %h", exp_r.en, energy);
          errors++;
        end
        for (int i = 0; i < 3; i++) begin
          if (got1[i] !== exp_r.f1[i]) begin
            $error("%s exp %h got %h", f1_name[i], exp_r.f1[i], got1[i]);
            errors++;
          end
          if (got2[i] !== exp_r.f2[i]) begin
            $error("%s exp %h got %h", f2_name[i], exp_r.f2[i], got2[i]);
            errors++;
          end
        end
      end
    end
  end

  task automatic test_directed();
    logic signed [31:0] a1 [3], a2 [3];
    logic signed [31:0] ext [4] = '{32'h7fffffff, 32'h80000000, 32'h0, 32'hffffffff};
    write_reg(REG_SPRING, 32'h0001_0000);
    write_reg(REG_REST, 32'h0001_0000);
    a1 = '{0, 0, 0};
    a2 = '{0, 0, 0};
    send_pair(a1, a2);
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        a1 = '{ext[i], ext[j], ext[(i + j) % 4]};
        a2 = '{ext[j], ext[i], ext[(i + 3) % 4]};
        send_pair(a1, a2);
      end
    end
    a1 = '{0, 0, 0};
    a2 = '{32'h0001_0000, 0, 0};
    send_pair(a1, a2);
    a2 = '{32'h0000_8000, 32'hffff_0000, 32'h0002_0000};
    send_pair(a1, a2);
    drain();
  endtask

  task automatic test_extreme_config();
    write_reg(REG_SPRING, 32'hffffffff);
    write_reg(REG_REST, 32'hffffffff);
    send_random(40);
    drain();
    write_reg(REG_SPRING, 32'h0);
    write_reg(REG_REST, 32'h0);
    send_random(20);
    drain();
  endtask

  task automatic test_random_traffic();
    int mode [3][2] = '{'{34, 62}, '{62, 34}, '{0, 0}};
    for (int m = 0; m < 3; m++) begin
      send_idle_pct = mode[m][0];
      recv_idle_pct = mode[m][1];
      write_reg(REG_SPRING, $urandom_range(32'h0040_0000));
      write_reg(REG_REST, $urandom_range(32'h0008_0000));
      send_random(100);
      drain();
    end
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(REG_SPRING, $urandom());
    write_reg(REG_REST, $urandom());
    @(negedge clk);
    hold_cycles = 150;
    send_random(80);
    drain();
  endtask

  initial begin
    k_reg = '0;
    r0_reg = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_extreme_config();
    test_random_traffic();
    test_backpressure();
    if (errors == 0 && pending_results.size() == 0) $display("PASS harmonic_bond_force");
    else $display("FAIL harmonic_bond_force");
    $finish;
  end

  initial begin
    #400000;
    $display("FAIL harmonic_bond_force");
    $finish;
  end
endmodule

/* filelist.f */
+incdir+hdl
hdl/hbf_pkg.sv
hdl/hbf_isqrt.sv
hdl/hbf_div.sv
hdl/harmonic_bond_force.sv
hdl/hbf_checker.sv
tb/tb_top.sv
